// ===== hw/rtl/banked_ram_window_dirty_writeback_macros.svh =====
// ---------------------------------------------------------------------------
// banked ram window assertion macros
// concurrent checks that compile away under synthesis
// ---------------------------------------------------------------------------
`ifndef BANKED_RAM_WINDOW_DIRTY_WRITEBACK_MACROS_SVH
`define BANKED_RAM_WINDOW_DIRTY_WRITEBACK_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define BRW_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define BRW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BRW_ASSERT_SAME(label, clk, rstn, ante, cons)
`define BRW_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== hw/rtl/brw_pkg.sv =====
// ---------------------------------------------------------------------------
// brw_pkg
// shared types and constants of the banked ram window block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package brw_pkg;

    localparam int PAGES_DEF   = 64;
    localparam int PAGE_BYTES  = 256;
    localparam int OFFSET_W    = 8;
    localparam int PAGE_NUM_W  = 6;
    localparam int BYTE_W      = 8;
    localparam int CMD_W       = 3;
    localparam int DIRTY_BITS  = 64;

    // input word layout
    localparam int CMD_LSB     = 0;
    localparam int HPAGE_LSB   = CMD_LSB + CMD_W;
    localparam int OFFSET_LSB  = HPAGE_LSB + PAGE_NUM_W;
    localparam int DATA_LSB    = OFFSET_LSB + OFFSET_W;
    localparam int S_TDATA_W   = 32;

    // output word layout
    localparam int M_TDATA_W   = 24;
    localparam int M_TUSER_W   = 3;

    localparam logic [7:0] PAGE_REG_RESET = 8'h40;
    localparam logic [7:0] PAGE_FORCE     = 8'h40;
    localparam logic [7:0] WMODE_READ     = 8'hde;
    localparam logic [7:0] SYS_BLOCK      = 8'hff;
    localparam int         WMODE_BIT      = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_BLOCK_SEL  = 3'd0,
        CMD_PAGE_SET   = 3'd1,
        CMD_PAGE_READ  = 3'd2,
        CMD_WIN_WRITE  = 3'd3,
        CMD_WIN_READ   = 3'd4,
        CMD_HOST_FILL  = 3'd5,
        CMD_HOST_FETCH = 3'd6
    } cmd_e_t;

    typedef enum logic [1:0] {
        FK_NONE   = 2'd0,
        FK_LOAD   = 2'd1,
        FK_RELOAD = 2'd2
    } fetch_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESULT,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic accept;
        logic load_result;
        logic load_wb;
        logic scan_step;
    } ctl_cmd_t;

    typedef struct packed {
        logic start_scan;
        logic scan_bit;
        logic scan_last;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/brw_ram.sv =====
// ---------------------------------------------------------------------------
// brw_ram
// single port ram with registered read
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module brw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/brw_ctrl.sv =====
// ---------------------------------------------------------------------------
// brw_ctrl
// sequencer: accepts a word, issues the result or walks the dirty scan
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module brw_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire brw_pkg::dp_status_t  st,
    output brw_pkg::ctl_cmd_t         ctl
);

    import brw_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctl.accept = 1'b1;
                    state_next = st.start_scan ? ST_SCAN : ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (slot_free) begin
                    ctl.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_SCAN: begin
                // skip clean pages, hold on a dirty one until the slot frees
                if (!st.scan_bit) begin
                    ctl.scan_step = 1'b1;
                end else if (slot_free) begin
                    ctl.load_wb   = 1'b1;
                    ctl.scan_step = 1'b1;
                    if (st.scan_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (ctl.load_result || ctl.load_wb) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/brw_dp.sv =====
// ---------------------------------------------------------------------------
// brw_dp
// page register, dirty map, block store and output word register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module brw_dp #(
    parameter int PAGES = brw_pkg::PAGES_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [brw_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire brw_pkg::ctl_cmd_t               ctl,
    output brw_pkg::dp_status_t                  st,
    output logic      [brw_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic      [brw_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                                 m_tlast
);

    import brw_pkg::*;

    localparam int PAGE_AW   = $clog2(PAGES);
    localparam int RAM_DEPTH = PAGES * PAGE_BYTES;
    localparam int RAM_AW    = PAGE_AW + OFFSET_W;
    localparam logic [PAGE_NUM_W:0] PAGE_LIMIT = (PAGE_NUM_W + 1)'(PAGES);
    localparam int PAD_W     = M_TDATA_W - 2 * BYTE_W - PAGE_NUM_W;

    // incoming word fields
    cmd_e_t                in_cmd;
    logic [PAGE_NUM_W-1:0] in_hpage;
    logic [OFFSET_W-1:0]   in_offset;
    logic [BYTE_W-1:0]     in_data;

    assign in_cmd    = cmd_e_t'(s_tdata[CMD_LSB +: CMD_W]);
    assign in_hpage  = s_tdata[HPAGE_LSB +: PAGE_NUM_W];
    assign in_offset = s_tdata[OFFSET_LSB +: OFFSET_W];
    assign in_data   = s_tdata[DATA_LSB +: BYTE_W];

    // architectural state
    logic [BYTE_W-1:0]     page_reg, page_next;
    logic [BYTE_W-1:0]     cur_block_reg, cur_block_next;
    logic [DIRTY_BITS-1:0] dirty_reg, dirty_next;

    // scan state
    logic [DIRTY_BITS-1:0] scan_map_reg, scan_map_next;
    logic [PAGE_NUM_W-1:0] scan_ptr_reg, scan_ptr_next;

    // per item result staging
    logic                  use_ram_reg, use_ram_next;
    logic [BYTE_W-1:0]     imm_reg, imm_next;
    fetch_kind_t           kind_reg, kind_next;
    logic [BYTE_W-1:0]     fblk_reg, fblk_next;

    // output word
    logic [BYTE_W-1:0]     rd_reg, rd_next;
    logic                  wbv_reg, wbv_next;
    logic [PAGE_NUM_W-1:0] wbp_reg, wbp_next;
    fetch_kind_t           okind_reg, okind_next;
    logic [BYTE_W-1:0]     oblk_reg, oblk_next;
    logic                  olast_reg, olast_next;

    logic [PAGE_NUM_W-1:0] wpage;
    logic                  wmode;
    logic [PAGE_NUM_W-1:0] sel_page;
    logic                  ram_we;
    logic [RAM_AW-1:0]     ram_addr;
    logic [BYTE_W-1:0]     ram_q;
    logic [DIRTY_BITS-1:0] ptr_bit;

    function automatic logic page_ok(input logic [PAGE_NUM_W-1:0] p);
        return {1'b0, p} < PAGE_LIMIT;
    endfunction

    assign wpage    = page_reg[PAGE_NUM_W-1:0];
    assign wmode    = page_reg[WMODE_BIT];
    assign sel_page = (in_cmd == CMD_HOST_FILL || in_cmd == CMD_HOST_FETCH) ? in_hpage
                                                                             : wpage;
    assign ram_addr = {sel_page[PAGE_AW-1:0], in_offset};
    assign ptr_bit  = DIRTY_BITS'(1) << scan_ptr_reg;

    assign st.start_scan = (in_cmd == CMD_BLOCK_SEL) && (dirty_reg != '0);
    assign st.scan_bit   = scan_map_reg[scan_ptr_reg];
    assign st.scan_last  = (scan_map_reg & ~ptr_bit) == '0;

    brw_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ctl.accept),
        .addr  (ram_addr),
        .wdata (in_data),
        .rdata (ram_q)
    );

    always_comb begin
        page_next      = page_reg;
        cur_block_next = cur_block_reg;
        dirty_next     = dirty_reg;
        scan_map_next  = scan_map_reg;
        scan_ptr_next  = scan_ptr_reg;
        use_ram_next   = use_ram_reg;
        imm_next       = imm_reg;
        kind_next      = kind_reg;
        fblk_next      = fblk_reg;
        rd_next        = rd_reg;
        wbv_next       = wbv_reg;
        wbp_next       = wbp_reg;
        okind_next     = okind_reg;
        oblk_next      = oblk_reg;
        olast_next     = olast_reg;
        ram_we         = 1'b0;

        if (ctl.accept) begin
            use_ram_next = 1'b0;
            imm_next     = '0;
            kind_next    = FK_NONE;
            fblk_next    = '0;
            case (in_cmd)
                CMD_BLOCK_SEL: begin
                    scan_map_next = dirty_reg;
                    dirty_next    = '0;
                    scan_ptr_next = '1;
                    if (cur_block_reg != in_data) begin
                        cur_block_next = in_data;
                        page_next      = PAGE_REG_RESET;
                        kind_next      = FK_LOAD;
                        fblk_next      = in_data;
                    end else if (in_data == SYS_BLOCK) begin
                        page_next = PAGE_REG_RESET;
                        kind_next = FK_RELOAD;
                        fblk_next = in_data;
                    end
                end
                CMD_PAGE_SET: begin
                    if (in_data[WMODE_BIT]) begin
                        dirty_next = dirty_reg
                                   | (DIRTY_BITS'(1) << in_data[PAGE_NUM_W-1:0]);
                    end
                    page_next = in_data | PAGE_FORCE;
                end
                CMD_PAGE_READ: begin
                    imm_next = page_reg;
                end
                CMD_WIN_WRITE: begin
                    ram_we = wmode && page_ok(wpage);
                end
                CMD_WIN_READ: begin
                    if (wmode) begin
                        imm_next = WMODE_READ;
                    end else begin
                        use_ram_next = page_ok(wpage);
                    end
                end
                CMD_HOST_FILL: begin
                    ram_we = page_ok(in_hpage);
                end
                CMD_HOST_FETCH: begin
                    use_ram_next = page_ok(in_hpage);
                end
                default: begin
                end
            endcase
        end

        if (ctl.load_result) begin
            rd_next    = use_ram_reg ? ram_q : imm_reg;
            wbv_next   = 1'b0;
            wbp_next   = '0;
            okind_next = kind_reg;
            oblk_next  = fblk_reg;
            olast_next = 1'b1;
        end

        if (ctl.load_wb) begin
            rd_next       = '0;
            wbv_next      = 1'b1;
            wbp_next      = scan_ptr_reg;
            // fetch request rides on the lowest dirty page
            okind_next    = st.scan_last ? kind_reg : FK_NONE;
            oblk_next     = st.scan_last ? fblk_reg : '0;
            olast_next    = st.scan_last;
            scan_map_next = scan_map_reg & ~ptr_bit;
        end

        if (ctl.scan_step) begin
            scan_ptr_next = scan_ptr_reg - PAGE_NUM_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_reg      <= PAGE_REG_RESET;
            cur_block_reg <= SYS_BLOCK;
            dirty_reg     <= '0;
            scan_map_reg  <= '0;
        end else begin
            page_reg      <= page_next;
            cur_block_reg <= cur_block_next;
            dirty_reg     <= dirty_next;
            scan_map_reg  <= scan_map_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_ptr_reg <= scan_ptr_next;
        use_ram_reg  <= use_ram_next;
        imm_reg      <= imm_next;
        kind_reg     <= kind_next;
        fblk_reg     <= fblk_next;
        rd_reg       <= rd_next;
        wbv_reg      <= wbv_next;
        wbp_reg      <= wbp_next;
        okind_reg    <= okind_next;
        oblk_reg     <= oblk_next;
        olast_reg    <= olast_next;
    end

    assign m_tdata = {{PAD_W{1'b0}}, oblk_reg, wbp_reg, rd_reg};
    assign m_tuser = {okind_reg, wbv_reg};
    assign m_tlast = olast_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/banked_ram_window_dirty_writeback.sv =====
// ---------------------------------------------------------------------------
// banked_ram_window_dirty_writeback
// paged ram window with dirty tracking and host writeback requests
// ---------------------------------------------------------------------------
// One command word is taken at a time. A page, window or host command, or a
// block select with no dirty page, puts its single result word into the output
// register once the output slot is free (the store's registered read is
// captured on the taking edge, the output register loads from the result
// state), and no new word is taken before that result is loaded. A block
// select with dirty pages walks a pointer over the 64 dirty bits from page 63
// downward, one bit per cycle unless a dirty page waits for a busy output
// slot, and gives one writeback word per dirty page, ending at the lowest dirty
// page. The fetch request and tlast travel on the last word. The block store
// is not cleared after reset: a byte reads as defined only after it was written.
`timescale 1ns / 1ps
`default_nettype none
`include "banked_ram_window_dirty_writeback_macros.svh"

module banked_ram_window_dirty_writeback #(
    parameter int PAGES = brw_pkg::PAGES_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // cmd[2:0], host_page[8:3], offset[16:9], data[24:17]
    input  wire logic [brw_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // read_data[7:0], writeback_page[13:8], fetch_block[21:14]
    output logic      [brw_pkg::M_TDATA_W-1:0]  m_tdata,
    // writeback_valid[0], fetch_kind[2:1]
    output logic      [brw_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready
);

    import brw_pkg::*;

    ctl_cmd_t    ctl;
    dp_status_t  st;
    fetch_kind_t out_kind;

    assign out_kind = fetch_kind_t'(m_tuser[2:1]);

    brw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .ctl      (ctl)
    );

    brw_dp #(
        .PAGES (PAGES)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .ctl     (ctl),
        .st      (st),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // fetch request only on the closing word of a block select
    `BRW_ASSERT_SAME(a_fetch_on_last, aclk, aresetn, m_tvalid && !m_tlast, out_kind == FK_NONE)
    // only writeback words may leave tlast low
    `BRW_ASSERT_SAME(a_nonlast_is_wb, aclk, aresetn, m_tvalid && !m_tlast, m_tuser[0])
    // no fetch kind beyond reload
    `BRW_ASSERT_SAME(a_kind_legal, aclk, aresetn, m_tvalid, out_kind <= FK_RELOAD)
    // one word in flight: input closes right after a take
    `BRW_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule

`default_nettype wire
